// File: src/dlr_pkg.sv
// Shared constants and types for the line depth rasteriser.
`default_nettype none

package dlr_pkg;

  localparam int FRAC_BITS_DEFAULT  = 16;
  localparam int COORD_BITS_DEFAULT = 16;
  localparam int HEIGHT_BITS        = 16;
  localparam int DEPTH_BITS         = 17;
  localparam int DEPTH_FRAC_BITS    = 16;
  localparam int CFG_INDEX_BITS     = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT_MIN = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT_MAX = 1'b1;

  localparam logic MODE_START = 1'b0;

  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1) << DEPTH_FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PREP,
    ST_CHECK,
    ST_DEPTH_WAIT,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_Z
  } div_sel_t;

endpackage

`default_nettype wire

// File: src/dda_line_depth_rasterizer.sv
// DDA line rasteriser with height interpolation and normalised depth output.
// Requests arrive on the input channel (in_valid / in_stall). A request with mode
// 0 loads two endpoints and two heights and produces the first pixel; a request
// with mode 1 steps to the next pixel and produces it. An advance request while
// no line is active is consumed and produces nothing. Each pixel leaves on the
// output channel (out_valid / out_stall) from an output register, so the next
// request is taken while a pixel still waits there.
// One restoring divider, one bit per cycle, does all the divisions. A line start
// runs three increment divisions (x, y, then height), then the depth step; a
// zero-length line skips the divisions. Each pixel runs the depth division only
// when the depth is neither 0 nor saturated.
// height_min and height_max are written through cfg_write / cfg_index / cfg_data.
// The user must write them only while the block is idle; the block itself does
// not enforce this. Reset clears the line (idle, no pending pixel) and sets
// height_min to 0 and height_max to 1. When out_stall holds a pixel in the
// output register, the next pixel waits in the block and in_stall stays high.
`default_nettype none

module dda_line_depth_rasterizer
  import dlr_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [HEIGHT_BITS-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic signed [COORD_BITS-1:0]  x_start,
  input  logic signed [COORD_BITS-1:0]  y_start,
  input  logic signed [COORD_BITS-1:0]  x_end,
  input  logic signed [COORD_BITS-1:0]  y_end,
  input  logic signed [HEIGHT_BITS-1:0] z_start,
  input  logic signed [HEIGHT_BITS-1:0] z_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  pixel_x,
  output logic signed [COORD_BITS-1:0]  pixel_y,
  output logic [DEPTH_BITS-1:0]         depth_fraction,
  output logic                          flat_range,
  output logic                          last
);

  localparam int MAG_BITS   = (COORD_BITS > HEIGHT_BITS) ? COORD_BITS : HEIGHT_BITS;
  localparam int PACC_BITS  = COORD_BITS + FRAC_BITS + 2;
  localparam int HACC_BITS  = MAG_BITS + FRAC_BITS + 2;
  localparam int XINC_BITS  = FRAC_BITS + 2;
  localparam int ZINC_BITS  = FRAC_BITS + HEIGHT_BITS + 2;
  localparam int NUM_BITS   = MAG_BITS + FRAC_BITS + 2;
  localparam int QUO_BITS   = MAG_BITS + FRAC_BITS + 1;
  localparam int DEN_BITS   = (COORD_BITS + 1 > HEIGHT_BITS + FRAC_BITS) ?
                              COORD_BITS + 1 : HEIGHT_BITS + FRAC_BITS;
  localparam int CNT_BITS   = $clog2(NUM_BITS + 1);
  localparam int NUMD_BITS  = HACC_BITS + 1;
  localparam int RND_BITS   = PACC_BITS - FRAC_BITS + 1;
  localparam int COORD_HI   = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_LIM  = 1 << (COORD_BITS - 1);

  state_t   state;
  state_t   state_next;
  div_sel_t div_sel;

  logic signed [HEIGHT_BITS-1:0] height_min;
  logic signed [HEIGHT_BITS-1:0] height_max;

  logic signed [PACC_BITS-1:0] pos_x_acc;
  logic signed [PACC_BITS-1:0] pos_y_acc;
  logic signed [HACC_BITS-1:0] height_acc;
  logic signed [XINC_BITS-1:0] x_increment;
  logic signed [XINC_BITS-1:0] y_increment;
  logic signed [ZINC_BITS-1:0] height_increment;
  logic [COORD_BITS-1:0]       steps_left;
  logic                        line_active;
  logic                        last_flag;

  logic signed [COORD_BITS:0]  delta_x;
  logic signed [COORD_BITS:0]  delta_y;
  logic signed [HEIGHT_BITS:0] delta_z;
  logic [COORD_BITS-1:0]       mag_x;
  logic [COORD_BITS-1:0]       mag_y;
  logic [HEIGHT_BITS-1:0]      mag_z;
  logic                        neg_x;
  logic                        neg_y;
  logic                        neg_z;

  logic [NUMD_BITS-1:0]   num_mag;
  logic                   num_neg;
  logic                   num_zero;
  logic [HEIGHT_BITS-1:0] den_mag;
  logic                   den_neg;
  logic                   den_zero;

  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic [DEPTH_BITS-1:0] res_depth;
  logic                  res_flat;

  logic                  in_accept;
  logic                  out_load;

  logic [COORD_BITS:0]   abs_x;
  logic [COORD_BITS:0]   abs_y;
  logic [HEIGHT_BITS:0]  abs_z;
  logic [COORD_BITS-1:0] setup_steps;

  logic [MAG_BITS-1:0]         sel_mag;
  logic                        sel_neg;
  logic signed [XINC_BITS-1:0] quo_xy;
  logic signed [ZINC_BITS-1:0] quo_z;
  logic signed [XINC_BITS-1:0] inc_xy;
  logic signed [ZINC_BITS-1:0] inc_z;

  logic signed [NUMD_BITS-1:0]   num_c;
  logic [NUMD_BITS-1:0]          num_abs;
  logic signed [HEIGHT_BITS:0]   den_c;
  logic [HEIGHT_BITS:0]          den_abs;
  logic                          depth_trivial;
  logic                          depth_full;

  logic                div_start;
  logic [DEN_BITS-1:0] div_rem_init;
  logic [NUM_BITS-1:0] div_numer;
  logic [DEN_BITS-1:0] div_denom;
  logic [CNT_BITS-1:0] div_iters;
  logic [QUO_BITS-1:0] div_quo;
  logic                div_done;

  // Round half away from zero to whole pixels and clamp to the coordinate range.
  function automatic logic [COORD_BITS-1:0] coord_round(
    input logic signed [PACC_BITS-1:0] acc
  );
    logic [PACC_BITS-1:0]  amag;
    logic [PACC_BITS:0]    biased;
    logic [RND_BITS-1:0]   rounded;
    logic [COORD_BITS-1:0] res;
    amag    = acc[PACC_BITS-1] ? PACC_BITS'(-acc) : PACC_BITS'(acc);
    biased  = (PACC_BITS+1)'(amag) + ((PACC_BITS+1)'(1) << (FRAC_BITS - 1));
    rounded = biased[PACC_BITS:FRAC_BITS];
    res     = rounded[COORD_BITS-1:0];
    if (!acc[PACC_BITS-1]) begin
      if (rounded > RND_BITS'(COORD_HI)) begin
        res = COORD_BITS'(COORD_HI);
      end
    end else begin
      if (rounded > RND_BITS'(COORD_LIM)) begin
        res = COORD_BITS'(COORD_LIM);
      end else begin
        res = ~res + COORD_BITS'(1);
      end
    end
    return res;
  endfunction

  dlr_div #(
    .NUM_BITS (NUM_BITS),
    .DEN_BITS (DEN_BITS),
    .QUO_BITS (QUO_BITS),
    .CNT_BITS (CNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .numer    (div_numer),
    .denom    (div_denom),
    .iters    (div_iters),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign in_accept = in_valid && !in_stall;

  // Step count from the registered endpoint differences.
  assign abs_x       = delta_x[COORD_BITS] ? (COORD_BITS+1)'(-delta_x) : delta_x;
  assign abs_y       = delta_y[COORD_BITS] ? (COORD_BITS+1)'(-delta_y) : delta_y;
  assign abs_z       = delta_z[HEIGHT_BITS] ? (HEIGHT_BITS+1)'(-delta_z) : delta_z;
  assign setup_steps = (abs_x[COORD_BITS-1:0] > abs_y[COORD_BITS-1:0]) ?
                       abs_x[COORD_BITS-1:0] : abs_y[COORD_BITS-1:0];

  always_comb begin
    case (div_sel)
      SEL_X: begin
        sel_mag = MAG_BITS'(mag_x);
        sel_neg = neg_x;
      end
      SEL_Y: begin
        sel_mag = MAG_BITS'(mag_y);
        sel_neg = neg_y;
      end
      default: begin
        sel_mag = MAG_BITS'(mag_z);
        sel_neg = neg_z;
      end
    endcase
  end

  assign quo_xy = XINC_BITS'(div_quo);
  assign quo_z  = ZINC_BITS'(div_quo);
  assign inc_xy = sel_neg ? -quo_xy : quo_xy;
  assign inc_z  = sel_neg ? -quo_z : quo_z;

  // Depth numerator and denominator, taken apart into sign and magnitude.
  assign num_c   = NUMD_BITS'(height_acc) - (NUMD_BITS'(height_min) <<< FRAC_BITS);
  assign num_abs = num_c[NUMD_BITS-1] ? NUMD_BITS'(-num_c) : NUMD_BITS'(num_c);
  assign den_c   = (HEIGHT_BITS+1)'(height_max) - (HEIGHT_BITS+1)'(height_min);
  assign den_abs = den_c[HEIGHT_BITS] ? (HEIGHT_BITS+1)'(-den_c) : (HEIGHT_BITS+1)'(den_c);

  assign depth_trivial = den_zero || num_zero || (num_neg != den_neg);
  assign depth_full    = num_mag >= (NUMD_BITS'(den_mag) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    div_start    = 1'b0;
    div_rem_init = '0;
    div_numer    = '0;
    div_denom    = '0;
    div_iters    = '0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (mode == MODE_START) begin
            state_next = ST_SETUP;
          end else if (line_active) begin
            state_next = ST_PREP;
          end
        end
      end
      ST_SETUP: begin
        state_next = (setup_steps == '0) ? ST_PREP : ST_DIV_GO;
      end
      ST_DIV_GO: begin
        // Rounded increment: (2 * |d| * 2^F + steps) / (2 * steps).
        div_start  = 1'b1;
        div_numer  = (NUM_BITS'(sel_mag) << (FRAC_BITS + 1)) + NUM_BITS'(steps_left);
        div_denom  = DEN_BITS'({steps_left, 1'b0});
        div_iters  = CNT_BITS'(NUM_BITS);
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (div_sel == SEL_Z) ? ST_PREP : ST_DIV_GO;
        end
      end
      ST_PREP: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (depth_trivial || depth_full) begin
          state_next = ST_RESULT;
        end else begin
          // The numerator is below the divisor here, so it seeds the remainder.
          div_start    = 1'b1;
          div_rem_init = DEN_BITS'(num_mag);
          div_denom    = DEN_BITS'(den_mag) << FRAC_BITS;
          div_iters    = CNT_BITS'(DEPTH_FRAC_BITS);
          state_next   = ST_DEPTH_WAIT;
        end
      end
      ST_DEPTH_WAIT: begin
        if (div_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      height_min <= '0;
      height_max <= HEIGHT_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEIGHT_MIN: height_min <= cfg_data;
        REG_HEIGHT_MAX: height_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      steps_left  <= '0;
      last_flag   <= 1'b0;
      div_sel     <= SEL_X;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && mode != MODE_START && line_active) begin
            steps_left  <= steps_left - COORD_BITS'(1);
            line_active <= steps_left != COORD_BITS'(1);
            last_flag   <= steps_left == COORD_BITS'(1);
          end
        end
        ST_SETUP: begin
          steps_left  <= setup_steps;
          line_active <= setup_steps != '0;
          last_flag   <= setup_steps == '0;
          div_sel     <= SEL_X;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            case (div_sel)
              SEL_X:   div_sel <= SEL_Y;
              SEL_Y:   div_sel <= SEL_Z;
              default: div_sel <= SEL_X;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (mode == MODE_START) begin
            delta_x    <= (COORD_BITS+1)'(x_end) - (COORD_BITS+1)'(x_start);
            delta_y    <= (COORD_BITS+1)'(y_end) - (COORD_BITS+1)'(y_start);
            delta_z    <= (HEIGHT_BITS+1)'(z_end) - (HEIGHT_BITS+1)'(z_start);
            pos_x_acc  <= PACC_BITS'(x_start) <<< FRAC_BITS;
            pos_y_acc  <= PACC_BITS'(y_start) <<< FRAC_BITS;
            height_acc <= HACC_BITS'(z_start) <<< FRAC_BITS;
          end else if (line_active) begin
            pos_x_acc  <= pos_x_acc + PACC_BITS'(x_increment);
            pos_y_acc  <= pos_y_acc + PACC_BITS'(y_increment);
            height_acc <= height_acc + HACC_BITS'(height_increment);
          end
        end
      end
      ST_SETUP: begin
        mag_x <= abs_x[COORD_BITS-1:0];
        mag_y <= abs_y[COORD_BITS-1:0];
        mag_z <= abs_z[HEIGHT_BITS-1:0];
        neg_x <= delta_x[COORD_BITS];
        neg_y <= delta_y[COORD_BITS];
        neg_z <= delta_z[HEIGHT_BITS];
        if (setup_steps == '0) begin
          x_increment      <= '0;
          y_increment      <= '0;
          height_increment <= '0;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (div_sel)
            SEL_X:   x_increment      <= inc_xy;
            SEL_Y:   y_increment      <= inc_xy;
            default: height_increment <= inc_z;
          endcase
        end
      end
      ST_PREP: begin
        num_mag  <= num_abs;
        num_neg  <= num_c[NUMD_BITS-1];
        num_zero <= num_c == '0;
        den_mag  <= den_abs[HEIGHT_BITS-1:0];
        den_neg  <= den_c[HEIGHT_BITS];
        den_zero <= den_c == '0;
        res_x    <= coord_round(pos_x_acc);
        res_y    <= coord_round(pos_y_acc);
      end
      ST_CHECK: begin
        res_flat <= den_zero;
        if (depth_trivial) begin
          res_depth <= '0;
        end else if (depth_full) begin
          res_depth <= DEPTH_ONE;
        end
      end
      ST_DEPTH_WAIT: begin
        if (div_done) begin
          res_depth <= DEPTH_BITS'(div_quo[DEPTH_FRAC_BITS-1:0]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_x        <= res_x;
      pixel_y        <= res_y;
      depth_fraction <= res_depth;
      flat_range     <= res_flat;
      last           <= last_flag;
    end
  end

endmodule

`default_nettype wire

// File: src/dlr_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module dlr_div
  import dlr_pkg::*;
#(
  parameter int NUM_BITS = HEIGHT_BITS + FRAC_BITS_DEFAULT + 2,
  parameter int DEN_BITS = HEIGHT_BITS + FRAC_BITS_DEFAULT,
  parameter int QUO_BITS = HEIGHT_BITS + FRAC_BITS_DEFAULT + 1,
  parameter int CNT_BITS = $clog2(NUM_BITS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DEN_BITS-1:0] rem_init,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  input  logic [CNT_BITS-1:0] iters,
  output logic [QUO_BITS-1:0] quotient,
  output logic                done
);

  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den;
  logic [NUM_BITS-1:0] num_sh;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // The remainder stays below the divisor, so the trial value needs one extra bit.
  assign trial = {rem, num_sh[NUM_BITS-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= iters;
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= rem_init;
      den      <= denom;
      num_sh   <= numer;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      num_sh   <= num_sh << 1;
      quotient <= {quotient[QUO_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for the line depth rasteriser: directed and random requests checked against a predictor.
module tb;
  import dlr_pkg::*;

  localparam int FRAC = FRAC_BITS_DEFAULT;
  localparam int CW = COORD_BITS_DEFAULT;
  localparam logic MODE_ADVANCE = ~MODE_START;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int SETTLE_CYCLES = 300;
  localparam int DRAIN_LIMIT = 50000;
  localparam int REPORT_LIMIT = 10;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam longint COORD_HI = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;

  typedef struct packed {
    logic                   mode;
    logic [CW-1:0]          x_start;
    logic [CW-1:0]          y_start;
    logic [CW-1:0]          x_end;
    logic [CW-1:0]          y_end;
    logic [HEIGHT_BITS-1:0] z_start;
    logic [HEIGHT_BITS-1:0] z_end;
  } line_req_t;

  typedef struct packed {
    logic [CW-1:0]         x;
    logic [CW-1:0]         y;
    logic [DEPTH_BITS-1:0] depth;
    logic                  flat;
    logic                  last;
  } pixel_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [HEIGHT_BITS-1:0]        cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          mode = 1'b0;
  logic signed [CW-1:0]          x_start = '0;
  logic signed [CW-1:0]          y_start = '0;
  logic signed [CW-1:0]          x_end = '0;
  logic signed [CW-1:0]          y_end = '0;
  logic signed [HEIGHT_BITS-1:0] z_start = '0;
  logic signed [HEIGHT_BITS-1:0] z_end = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [CW-1:0]          pixel_x;
  logic signed [CW-1:0]          pixel_y;
  logic [DEPTH_BITS-1:0]         depth_fraction;
  logic                          flat_range;
  logic                          last;

  dda_line_depth_rasterizer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .z_start(z_start), .z_end(z_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .depth_fraction(depth_fraction),
    .flat_range(flat_range), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: Q16.16 accumulators, increments and the depth range.
  longint range_lo = 0;
  longint range_hi = 1;
  longint acc_x = 0, acc_y = 0, acc_h = 0;
  longint inc_x = 0, inc_y = 0, inc_h = 0;
  longint steps_rem = 0;
  bit     drawing = 1'b0;

  line_req_t pending[$];
  pixel_t    pixels_due[$];
  int        tx_idle = 8;
  int        rx_idle = 54;
  int        mismatches = 0;
  bit        req_taken = 1'b0;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint widen(logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic int rand_word();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int clamp_word(int v);
    if (v > COORD_HI) return int'(COORD_HI);
    if (v < COORD_LO) return int'(COORD_LO);
    return v;
  endfunction

  function automatic int span(line_req_t r);
    longint dx, dy;
    dx = magnitude(widen(r.x_end) - widen(r.x_start));
    dy = magnitude(widen(r.y_end) - widen(r.y_start));
    return int'((dx > dy) ? dx : dy);
  endfunction

  // Per-step increment, rounded half away from zero.
  function automatic longint dda_increment(longint d, longint steps);
    longint q;
    q = ((magnitude(d) << FRAC) * 2 + steps) / (2 * steps);
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic [CW-1:0] round_coord(longint acc);
    longint r;
    r = (magnitude(acc) + (ONE_Q >> 1)) >> FRAC;
    if (acc < 0) r = -r;
    if (r > COORD_HI) r = COORD_HI;
    if (r < COORD_LO) r = COORD_LO;
    return r[CW-1:0];
  endfunction

  function automatic pixel_t shade_pixel(bit is_last);
    pixel_t p;
    longint den, num, depth;
    den = range_hi - range_lo;
    num = acc_h - range_lo * ONE_Q;
    depth = 0;
    // A reversed range still works as long as numerator and range share a sign.
    if (den != 0 && num != 0 && ((num < 0) == (den < 0))) begin
      depth = (magnitude(num) << DEPTH_FRAC_BITS) / (magnitude(den) << FRAC);
      if (depth > longint'(DEPTH_ONE)) depth = longint'(DEPTH_ONE);
    end
    p.x = round_coord(acc_x);
    p.y = round_coord(acc_y);
    p.depth = depth[DEPTH_BITS-1:0];
    p.flat = (den == 0);
    p.last = is_last;
    return p;
  endfunction

  task automatic rasterise(input line_req_t r);
    longint steps;
    if (r.mode == MODE_START) begin
      steps = span(r);
      acc_x = widen(r.x_start) * ONE_Q;
      acc_y = widen(r.y_start) * ONE_Q;
      acc_h = widen(r.z_start) * ONE_Q;
      if (steps == 0) begin
        inc_x = 0;
        inc_y = 0;
        inc_h = 0;
      end else begin
        inc_x = dda_increment(widen(r.x_end) - widen(r.x_start), steps);
        inc_y = dda_increment(widen(r.y_end) - widen(r.y_start), steps);
        inc_h = dda_increment(widen(r.z_end) - widen(r.z_start), steps);
      end
      steps_rem = steps;
      drawing = (steps != 0);
      pixels_due.push_back(shade_pixel(steps == 0));
    end else if (drawing) begin
      acc_x += inc_x;
      acc_y += inc_y;
      acc_h += inc_h;
      steps_rem--;
      if (steps_rem == 0) drawing = 1'b0;
      pixels_due.push_back(shade_pixel(steps_rem == 0));
    end
  endtask

  function automatic line_req_t noise_req();
    line_req_t r;
    r.mode = 1'($urandom);
    r.x_start = CW'($urandom);
    r.y_start = CW'($urandom);
    r.x_end = CW'($urandom);
    r.y_end = CW'($urandom);
    r.z_start = HEIGHT_BITS'($urandom);
    r.z_end = HEIGHT_BITS'($urandom);
    return r;
  endfunction

  function automatic line_req_t start_req(int x0, int y0, int x1, int y1, int z0, int z1);
    line_req_t r;
    r.mode = MODE_START;
    r.x_start = CW'(x0);
    r.y_start = CW'(y0);
    r.x_end = CW'(x1);
    r.y_end = CW'(y1);
    r.z_start = HEIGHT_BITS'(z0);
    r.z_end = HEIGHT_BITS'(z1);
    return r;
  endfunction

  task automatic queue_advances(input int count);
    line_req_t r;
    for (int i = 0; i < count; i++) begin
      r = noise_req();
      r.mode = MODE_ADVANCE;
      pending.push_back(r);
    end
  endtask

  // Heights mostly fall inside the programmed range so that depth takes mid values.
  function automatic int pick_height();
    int lo, hi;
    lo = int'((range_lo < range_hi) ? range_lo : range_hi);
    hi = int'((range_lo < range_hi) ? range_hi : range_lo);
    if ($urandom_range(9) < 4) return rand_word();
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int pick_corner();
    if ($urandom_range(9) != 0) return rand_word();
    return ($urandom_range(1) == 1) ? int'(COORD_HI) : int'(COORD_LO);
  endfunction

  // Mostly whole lines of random geometry; some are cut short by a new start,
  // some overrun into ignored advances, and a few requests are pure noise.
  task automatic queue_line_traffic(input int n);
    int made, left, roll, reach, x0, y0, x1, y1, steps, k, extra, off;
    line_req_t r;
    made = 0;
    left = 0;
    while (made < n) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        r = noise_req();
        pending.push_back(r);
        if (r.mode == MODE_START) begin
          left = span(r);
          made++;
        end else if (left > 0) begin
          left--;
          made++;
        end
      end else begin
        roll = $urandom_range(99);
        reach = (roll < 90) ? 12 : (roll < 98) ? 64 : 65535;
        x0 = pick_corner();
        y0 = pick_corner();
        off = $urandom_range(2 * reach);
        x1 = clamp_word(x0 + off - reach);
        off = $urandom_range(2 * reach);
        y1 = clamp_word(y0 + off - reach);
        r = start_req(x0, y0, x1, y1, pick_height(), pick_height());
        pending.push_back(r);
        made++;
        steps = span(r);
        k = steps;
        if (reach == 65535) k = $urandom_range(4);
        else if ($urandom_range(9) == 0) k = $urandom_range(steps);
        extra = (k >= steps && $urandom_range(9) == 0) ? $urandom_range(2, 1) : 0;
        queue_advances(k + extra);
        if (k > steps) k = steps;
        made += k;
        left = steps - k;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= HEIGHT_BITS'(value);
    @(posedge clk);
    if (idx == REG_HEIGHT_MIN) range_lo = value;
    else range_hi = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every request is taken and every pixel has come back, then let
  // the block finish any advance that produces nothing.
  task automatic settle();
    int waited;
    while (pending.size() != 0) @(posedge clk);
    waited = 0;
    while (pixels_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pixels_due.size() != 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("missing pixels: %0d still expected", pixels_due.size());
      mismatches += pixels_due.size();
      pixels_due.delete();
    end
  endtask

  // Request side: the head of the queue is on the port whenever in_valid is high.
  always @(posedge clk) begin
    req_taken = !rst && in_valid && !in_stall;
    if (req_taken) rasterise(pending.pop_front());
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle);
    if (!in_valid || req_taken) begin
      if (!rst && pending.size() != 0 && $urandom_range(99) >= tx_idle) begin
        in_valid <= 1'b1;
        mode <= pending[0].mode;
        x_start <= pending[0].x_start;
        y_start <= pending[0].y_start;
        x_end <= pending[0].x_end;
        y_end <= pending[0].y_end;
        z_start <= pending[0].z_start;
        z_end <= pending[0].z_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {pixel_x, pixel_y, depth_fraction, flat_range, last};
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected pixel: x=%0d y=%0d depth=%0d flat=%0b last=%0b",
                   $signed(got.x), $signed(got.y), got.depth, got.flat, got.last);
      end else begin
        want = pixels_due.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.depth !== want.depth ||
            got.flat !== want.flat || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("pixel mismatch: expected x=%0d y=%0d depth=%0d flat=%0b last=%0b",
                     $signed(want.x), $signed(want.y), want.depth, want.flat, want.last);
            $display("                got      x=%0d y=%0d depth=%0d flat=%0b last=%0b",
                     $signed(got.x), $signed(got.y), got.depth, got.flat, got.last);
          end
        end
      end
    end
  end

  initial begin
    int lo, hi;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle advance, zero-length lines, full-span lines dropped by a
    // new start, short lines run to the end and beyond.
    queue_advances(1);
    pending.push_back(start_req(0, 0, 0, 0, 0, 0));
    pending.push_back(start_req(-32768, -32768, -32768, -32768, -32768, -32768));
    pending.push_back(start_req(32767, 32767, -32768, -32768, -32768, 32767));
    queue_advances(2);
    pending.push_back(start_req(-32768, 32767, 32767, -32768, 32767, -32768));
    queue_advances(1);
    pending.push_back(start_req(0, 0, 3, -2, 0, 1));
    queue_advances(4);
    pending.push_back(start_req(5, 5, 5, -1, 1, 0));
    queue_advances(6);
    pending.push_back(start_req(-2, 0, 2, 1, 0, 0));
    queue_advances(4);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin lo = -32768; hi = 32767; end
        1: begin lo = 100; hi = 100; end
        2: begin lo = 32767; hi = -32768; end
        3: begin lo = -32768; hi = -32768; end
        4: begin
          lo = rand_word();
          hi = clamp_word(lo + int'($urandom_range(300, 1)));
        end
        6: begin lo = 0; hi = 1; end
        default: begin lo = rand_word(); hi = rand_word(); end
      endcase
      write_reg(REG_HEIGHT_MIN, lo);
      write_reg(REG_HEIGHT_MAX, hi);
      if (phase < 3) begin
        tx_idle = 8;
        rx_idle = 54;
      end else if (phase < 6) begin
        tx_idle = 54;
        rx_idle = 8;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      queue_line_traffic(PHASE_ITEMS / 2);
      settle();
      queue_line_traffic(PHASE_ITEMS / 2);
      settle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: dda_line_depth_rasterizer.f
src/dlr_pkg.sv
src/dlr_div.sv
src/dda_line_depth_rasterizer.sv
tb/sv/tb.sv
